/* rtl/ldm_pkg.sv */
// Package for the lens distortion uv mapper: types, constants and fixed-point helpers.
package ldm_pkg;

    localparam int Q_W = 24;
    localparam int DIV_QW = 24;
    localparam int DIV_RW = 48;
    localparam int DIV_DW = 24;

    localparam logic signed [Q_W-1:0] QMAX = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0] QMIN = 24'sh800000;
    localparam logic signed [Q_W-1:0] HALF_Q = 24'sd32768;
    localparam logic signed [Q_W-1:0] ONE_Q = 24'sd65536;
    localparam logic signed [Q_W-1:0] FACT_X = 24'sd24576;
    localparam logic signed [Q_W-1:0] FACT_Y = 24'sd26624;
    localparam logic signed [Q_W-1:0] K4_Q = 24'sd0;
    localparam logic [16:0] EYE_SHIFT = 17'd3277;

    localparam logic [2:0] CFG_CENTER_X = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y = 3'd1;
    localparam logic [2:0] CFG_RADIAL_K1 = 3'd2;
    localparam logic [2:0] CFG_RADIAL_K2 = 3'd3;
    localparam logic [2:0] CFG_RADIAL_K3 = 3'd4;
    localparam logic [2:0] CFG_TANGENT_P1 = 3'd5;
    localparam logic [2:0] CFG_TANGENT_P2 = 3'd6;
    localparam logic [2:0] CFG_ASPECT_RATIO = 3'd7;

    typedef struct packed {
        logic [16:0] coord_u;
        logic [16:0] coord_v;
        logic        eye_select;
    } t_in;

    typedef struct packed {
        logic signed [23:0] mapped_u;
        logic signed [23:0] mapped_v;
    } t_out;

    function automatic logic signed [23:0] sat24(input logic signed [49:0] a);
        logic signed [23:0] r;
        if (a > 50'sd8388607) begin
            r = QMAX;
        end else if (a < -50'sd8388608) begin
            r = QMIN;
        end else begin
            r = a[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] mulq(input logic signed [23:0] a,
                                                input logic signed [23:0] b);
        logic signed [47:0] p;
        logic signed [49:0] t;
        p = a * b;
        t = (50'(p) + 50'sd32768) >>> 16;
        return sat24(t);
    endfunction

    function automatic logic signed [23:0] ctr_x(input logic signed [23:0] cx,
                                                 input logic eye);
        logic signed [23:0] r;
        if (!eye) begin
            r = cx;
        end else if (cx == QMIN) begin
            r = QMAX;
        end else begin
            r = -cx;
        end
        return r;
    endfunction

    function automatic logic signed [23:0] qsel(input logic [23:0] q,
                                                input logic ovf,
                                                input logic neg);
        logic [24:0] qm;
        logic [24:0] nm;
        logic signed [23:0] r;
        qm = ovf ? 25'h800000 : {1'b0, q};
        if (qm > 25'h800000) begin
            qm = 25'h800000;
        end
        nm = -qm;
        if (neg) begin
            r = nm[23:0];
        end else if (qm >= 25'h800000) begin
            r = QMAX;
        end else begin
            r = qm[23:0];
        end
        return r;
    endfunction

endpackage

/* rtl/lens_distortion_uv_mapper.sv */
// Top level of the lens distortion uv mapper pipeline.
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_data (coord_u, coord_v, eye_select)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (mapped_u, mapped_v)
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
// One item per cycle while the output is not stalled; the path runs through two 24-stage dividers
// (aspect division and polynomial reciprocal) plus eleven arithmetic stages.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// Each stage holds while the next is full and stalled; bubbles collapse.
module lens_distortion_uv_mapper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ldm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ldm_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_data
);
    import ldm_pkg::*;

    logic signed [23:0] r_cx, r_cy, r_k1, r_k2, r_k3, r_p1, r_p2;
    logic [22:0] r_asp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= 24'sd13107;
            r_cy  <= 24'sd0;
            r_k1  <= 24'sd39432;
            r_k2  <= -24'sd548;
            r_k3  <= 24'sd5520;
            r_p1  <= -24'sd1729;
            r_p2  <= 24'sd2604;
            r_asp <= 23'd108134;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X:     r_cx  <= i_cfg_data;
                CFG_CENTER_Y:     r_cy  <= i_cfg_data;
                CFG_RADIAL_K1:    r_k1  <= i_cfg_data;
                CFG_RADIAL_K2:    r_k2  <= i_cfg_data;
                CFG_RADIAL_K3:    r_k3  <= i_cfg_data;
                CFG_TANGENT_P1:   r_p1  <= i_cfg_data;
                CFG_TANGENT_P2:   r_p2  <= i_cfg_data;
                CFG_ASPECT_RATIO: r_asp <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    logic [22:0] asp_e;
    assign asp_e = (r_asp == 23'd0) ? 23'd1 : r_asp;

    // stage enables
    logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10, en11;
    logic d1_ready, d1_valid, d2_ready, d2_valid;

    // stage 1: x, aspect division set-up
    logic signed [49:0] s1_u, s1_x, s1_num;
    logic [17:0]        s1_mag;
    logic [47:0]        s1_rem;
    logic               s1_ovf;
    logic               r1_v;
    logic signed [23:0] r1_x;
    logic               r1_eye, r1_neg, r1_ovf;
    logic [47:0]        r1_rem;
    logic [23:0]        r1_den;

    always_comb begin
        if (i_in_data.eye_select) begin
            s1_u = 50'(i_in_data.coord_u) - 50'(EYE_SHIFT);
        end else begin
            s1_u = 50'(i_in_data.coord_u) + 50'(EYE_SHIFT);
        end
        s1_x   = (s1_u <<< 1) - 50'sd65536 - 50'(ctr_x(r_cx, i_in_data.eye_select));
        s1_num = (50'(i_in_data.coord_v) <<< 1) - 50'sd65536;
        s1_mag = s1_num[49] ? 18'(-s1_num) : 18'(s1_num);
        s1_rem = {14'd0, s1_mag, 16'd0} + 48'(asp_e >> 1);
        s1_ovf = s1_rem >= (48'(asp_e) << 24);
    end

    assign en1 = !r1_v || d1_ready;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_x   <= sat24(s1_x);
            r1_eye <= i_in_data.eye_select;
            r1_neg <= s1_num[49];
            r1_ovf <= s1_ovf;
            r1_rem <= s1_rem;
            r1_den <= {1'b0, asp_e};
        end
    end

    logic [DIV_QW-1:0] d1_quo;
    logic [26:0]       d1_pay;

    ldm_div #(
        .QW(DIV_QW),
        .RW(DIV_RW),
        .DW(DIV_DW),
        .PW(27)
    ) u_div_asp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r1_v),
        .o_ready(d1_ready),
        .i_rem  (r1_rem),
        .i_den  (r1_den),
        .i_pay  ({r1_x, r1_eye, r1_neg, r1_ovf}),
        .o_valid(d1_valid),
        .i_ready(en2),
        .o_quo  (d1_quo),
        .o_pay  (d1_pay)
    );

    // stages 2..8
    logic r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic signed [23:0] r2_x, r2_y;
    logic               r2_eye;
    logic signed [23:0] r3_x, r3_y, r3_xx, r3_yy, r3_xy;
    logic               r3_eye;
    logic signed [23:0] r4_x, r4_y, r4_xy, r4_r2, r4_a, r4_b;
    logic               r4_eye;
    logic signed [23:0] r5_x, r5_y, r5_r2, r5_pk, r5_t1, r5_t2, r5_t3, r5_t4;
    logic               r5_eye;
    logic signed [23:0] r6_r2, r6_pk, r6_xn, r6_yn;
    logic               r6_eye;
    logic signed [23:0] r7_poly, r7_xn, r7_yn;
    logic               r7_eye;
    logic [47:0]        r8_rem;
    logic [23:0]        r8_den;
    logic               r8_zero, r8_neg, r8_ovf, r8_eye;
    logic signed [23:0] r8_xn, r8_yn;

    logic signed [23:0] s2_y, s4_r2, s8_neg_poly;
    logic [23:0]        s8_mag;
    logic [47:0]        s8_rem;

    assign s2_y  = sat24(50'(qsel(d1_quo, d1_pay[0], d1_pay[1])) - 50'(r_cy));
    assign s4_r2 = sat24(50'(r3_xx) + 50'(r3_yy));
    assign s8_neg_poly = -r7_poly;
    assign s8_mag = r7_poly[23] ? s8_neg_poly : r7_poly;
    assign s8_rem = 48'h1_0000_0000 + 48'(s8_mag >> 1);

    assign en8 = !r8_v || d2_ready;
    assign en7 = !r7_v || en8;
    assign en6 = !r6_v || en7;
    assign en5 = !r5_v || en6;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else begin
            if (en2) r2_v <= d1_valid;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
            if (en6) r6_v <= r5_v;
            if (en7) r7_v <= r6_v;
            if (en8) r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_x   <= d1_pay[26:3];
            r2_eye <= d1_pay[2];
            r2_y   <= s2_y;
        end
        if (en3) begin
            r3_x   <= r2_x;
            r3_y   <= r2_y;
            r3_eye <= r2_eye;
            r3_xx  <= mulq(r2_x, r2_x);
            r3_yy  <= mulq(r2_y, r2_y);
            r3_xy  <= mulq(r2_x, r2_y);
        end
        if (en4) begin
            r4_x   <= r3_x;
            r4_y   <= r3_y;
            r4_eye <= r3_eye;
            r4_xy  <= r3_xy;
            r4_r2  <= s4_r2;
            r4_a   <= sat24(50'(s4_r2) + (50'(r3_xx) <<< 1));
            r4_b   <= sat24(50'(s4_r2) + (50'(r3_yy) <<< 1));
        end
        if (en5) begin
            r5_x   <= r4_x;
            r5_y   <= r4_y;
            r5_eye <= r4_eye;
            r5_r2  <= r4_r2;
            r5_pk  <= sat24(50'(r_k2) + 50'(mulq(r4_r2, r_k3)));
            r5_t1  <= mulq(r_p1, r4_xy);
            r5_t2  <= mulq(r_p2, r4_a);
            r5_t3  <= mulq(r_p1, r4_b);
            r5_t4  <= mulq(r_p2, r4_xy);
        end
        if (en6) begin
            r6_eye <= r5_eye;
            r6_r2  <= r5_r2;
            r6_pk  <= sat24(50'(r_k1) + 50'(mulq(r5_r2, r5_pk)));
            r6_xn  <= sat24(50'(r5_x)
                      + 50'(sat24((50'(r5_t1) <<< 1) + 50'(r5_t2))));
            r6_yn  <= sat24(50'(r5_y)
                      + 50'(sat24(50'(r5_t3) + (50'(r5_t4) <<< 1))));
        end
        if (en7) begin
            r7_eye  <= r6_eye;
            r7_xn   <= r6_xn;
            r7_yn   <= r6_yn;
            r7_poly <= sat24(50'(ONE_Q) + 50'(mulq(r6_r2, r6_pk)));
        end
        if (en8) begin
            r8_eye  <= r7_eye;
            r8_xn   <= r7_xn;
            r8_yn   <= r7_yn;
            r8_zero <= r7_poly == 24'sd0;
            r8_neg  <= r7_poly[23];
            r8_den  <= s8_mag;
            r8_rem  <= s8_rem;
            r8_ovf  <= s8_rem >= (48'(s8_mag) << 24);
        end
    end

    logic [DIV_QW-1:0] d2_quo;
    logic [51:0]       d2_pay;

    ldm_div #(
        .QW(DIV_QW),
        .RW(DIV_RW),
        .DW(DIV_DW),
        .PW(52)
    ) u_div_rcp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r8_v),
        .o_ready(d2_ready),
        .i_rem  (r8_rem),
        .i_den  (r8_den),
        .i_pay  ({r8_xn, r8_yn, r8_eye, r8_zero, r8_neg, r8_ovf}),
        .o_valid(d2_valid),
        .i_ready(en9),
        .o_quo  (d2_quo),
        .o_pay  (d2_pay)
    );

    // stages 9..11
    logic               r9_v, r10_v, r11_v;
    logic signed [23:0] s9_d;
    logic signed [23:0] r9_mx, r9_my, r9_fy;
    logic               r9_eye;
    logic signed [23:0] r10_ax, r10_ay, r10_fy;
    t_out               r11_out;

    assign s9_d = d2_pay[2] ? QMAX
                : sat24(50'(qsel(d2_quo, d2_pay[0], d2_pay[1])) + 50'(K4_Q));

    assign en11 = !r11_v || i_out_ready;
    assign en10 = !r10_v || en11;
    assign en9  = !r9_v || en10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
        end else begin
            if (en9)  r9_v  <= d2_valid;
            if (en10) r10_v <= r9_v;
            if (en11) r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en9) begin
            r9_mx  <= mulq(d2_pay[51:28], s9_d);
            r9_my  <= mulq(d2_pay[27:4], s9_d);
            r9_fy  <= mulq(FACT_Y, $signed({1'b0, asp_e}));
            r9_eye <= d2_pay[3];
        end
        if (en10) begin
            r10_ax <= sat24(50'(r9_mx) + 50'(ctr_x(r_cx, r9_eye)));
            r10_ay <= sat24(50'(r9_my) + 50'(r_cy));
            r10_fy <= r9_fy;
        end
        if (en11) begin
            r11_out.mapped_u <= sat24(50'(HALF_Q) + 50'(mulq(r10_ax, FACT_X)));
            r11_out.mapped_v <= sat24(50'(HALF_Q) + 50'(mulq(r10_ay, r10_fy)));
        end
    end

    assign o_out_valid = r11_v;
    assign o_out_data  = r11_out;

endmodule

/* rtl/ldm_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with valid/ready flow.
module ldm_div #(
    parameter int QW = 24,
    parameter int RW = 48,
    parameter int DW = 24,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [RW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic [QW-1:0] r_v;
    logic [QW-1:0] en;
    logic [RW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic [PW-1:0] r_pay [QW];

    always_comb begin
        en[QW-1] = !r_v[QW-1] || i_ready;
        for (int s = QW - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [RW-1:0] src_rem;
        logic [DW-1:0] src_den;
        logic [QW-1:0] src_quo;
        logic [PW-1:0] src_pay;
        logic          src_v;
        logic [RW-1:0] trial;
        logic          ge;
        logic [RW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign src_rem = i_rem;
            assign src_den = i_den;
            assign src_quo = '0;
            assign src_pay = i_pay;
            assign src_v   = i_valid;
        end else begin : g_next
            assign src_rem = r_rem[s-1];
            assign src_den = r_den[s-1];
            assign src_quo = r_quo[s-1];
            assign src_pay = r_pay[s-1];
            assign src_v   = r_v[s-1];
        end

        assign trial = RW'(src_den) << (QW - 1 - s);
        assign ge    = src_rem >= trial;
        assign n_rem = ge ? (src_rem - trial) : src_rem;
        assign n_quo = {src_quo[QW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en[s]) begin
                r_v[s] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_rem[s] <= n_rem;
                r_den[s] <= src_den;
                r_quo[s] <= n_quo;
                r_pay[s] <= src_pay;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule

/* bench/lens_distortion_uv_mapper_tb.sv */
// Testbench for the lens distortion uv mapper: random and directed items against a predictor.
`timescale 1ns / 1ps

module lens_distortion_uv_mapper_tb;
    import ldm_pkg::*;

    localparam int LATENCY = 59;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    longint lens_regs [8];
    t_out   expected_coords [$];
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    bit     sink_stall_on = 1'b1;

    lens_distortion_uv_mapper u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_q(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        return clamp_q((a * b + 32768) >>> 16);
    endfunction

    function automatic longint fix_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0 ? -num : num) << 16;
        q = (mag + den / 2) / den;
        if (q > 8388608) q = 8388608;
        return clamp_q(num < 0 ? -q : q);
    endfunction

    function automatic longint fix_recip(longint b);
        longint mag;
        longint q;
        if (b == 0) return 8388607;
        mag = b < 0 ? -b : b;
        q = ((64'sd1 <<< 32) + mag / 2) / mag;
        if (q > 8388608) q = 8388608;
        return clamp_q(b < 0 ? -q : q);
    endfunction

    function automatic t_out predict_mapping(t_in item);
        longint u, v, asp, cx, cy, x, y, xx, yy, xy, r2, poly, d, xn, yn, fy;
        t_out res;
        u = item.coord_u;
        v = item.coord_v;
        asp = lens_regs[CFG_ASPECT_RATIO] > 0 ? lens_regs[CFG_ASPECT_RATIO] : 1;
        u = item.eye_select ? u - 3277 : u + 3277;
        cx = item.eye_select ? clamp_q(-lens_regs[CFG_CENTER_X]) : lens_regs[CFG_CENTER_X];
        cy = lens_regs[CFG_CENTER_Y];
        x = clamp_q(clamp_q(2 * u - 65536) - cx);
        y = clamp_q(fix_div(2 * v - 65536, asp) - cy);
        xx = fix_mul(x, x);
        yy = fix_mul(y, y);
        xy = fix_mul(x, y);
        r2 = clamp_q(xx + yy);
        poly = clamp_q(lens_regs[CFG_RADIAL_K2] + fix_mul(r2, lens_regs[CFG_RADIAL_K3]));
        poly = clamp_q(lens_regs[CFG_RADIAL_K1] + fix_mul(r2, poly));
        poly = clamp_q(65536 + fix_mul(r2, poly));
        d = fix_recip(poly);
        xn = clamp_q(x + clamp_q(2 * fix_mul(lens_regs[CFG_TANGENT_P1], xy)
             + fix_mul(lens_regs[CFG_TANGENT_P2], clamp_q(r2 + 2 * xx))));
        yn = clamp_q(y + clamp_q(fix_mul(lens_regs[CFG_TANGENT_P1], clamp_q(r2 + 2 * yy))
             + 2 * fix_mul(lens_regs[CFG_TANGENT_P2], xy)));
        fy = fix_mul(26624, asp);
        res.mapped_u = 24'(clamp_q(32768 + fix_mul(clamp_q(fix_mul(xn, d) + cx), 24576)));
        res.mapped_v = 24'(clamp_q(32768 + fix_mul(clamp_q(fix_mul(yn, d) + cy), fy)));
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_coord(logic [16:0] u, logic [16:0] v, logic eye, bit gaps);
        t_in item;
        int gap;
        item.coord_u = u;
        item.coord_v = v;
        item.eye_select = eye;
        gap = gaps ? random_gap() : 0;
        i_cfg_we <= 1'b0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_coords.push_back(predict_mapping(item));
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_coords.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 24'(value);
        @(posedge i_clk);
        lens_regs[idx] = (idx == CFG_ASPECT_RATIO) ? (value & 64'h7FFFFF)
                         : longint'($signed(24'(value)));
    endtask

    task automatic load_reset_values();
        lens_regs[CFG_CENTER_X] = 13107;
        lens_regs[CFG_CENTER_Y] = 0;
        lens_regs[CFG_RADIAL_K1] = 39432;
        lens_regs[CFG_RADIAL_K2] = -548;
        lens_regs[CFG_RADIAL_K3] = 5520;
        lens_regs[CFG_TANGENT_P1] = -1729;
        lens_regs[CFG_TANGENT_P2] = 2604;
        lens_regs[CFG_ASPECT_RATIO] = 108134;
    endtask

    task automatic test_directed_corners();
        send_coord(17'd0, 17'd0, 1'b0, 1'b0);
        send_coord(17'd65536, 17'd65536, 1'b0, 1'b0);
        send_coord(17'd0, 17'd65536, 1'b1, 1'b0);
        send_coord(17'd65536, 17'd0, 1'b1, 1'b0);
        send_coord(17'd32768, 17'd32768, 1'b0, 1'b0);
        send_coord(17'd32768, 17'd32768, 1'b1, 1'b0);
        send_coord(17'h1FFFF, 17'h1FFFF, 1'b0, 1'b0);
        send_coord(17'h1FFFF, 17'h1FFFF, 1'b1, 1'b0);
        send_coord(17'h10001, 17'd1, 1'b0, 1'b0);
        drain_pipeline();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_CENTER_X, -8388608);
        write_reg(CFG_ASPECT_RATIO, 0);
        send_coord(17'd1000, 17'd50000, 1'b1, 1'b0);
        send_coord(17'd1000, 17'd50000, 1'b0, 1'b0);
        drain_pipeline();
        write_reg(CFG_CENTER_X, 8388607);
        write_reg(CFG_CENTER_Y, -8388608);
        write_reg(CFG_RADIAL_K1, 8388607);
        write_reg(CFG_RADIAL_K2, -8388608);
        write_reg(CFG_RADIAL_K3, 8388607);
        write_reg(CFG_TANGENT_P1, -8388608);
        write_reg(CFG_TANGENT_P2, 8388607);
        write_reg(CFG_ASPECT_RATIO, 8388607);
        send_coord(17'd0, 17'h1FFFF, 1'b0, 1'b0);
        send_coord(17'h1FFFF, 17'd0, 1'b1, 1'b0);
        drain_pipeline();
        // polynomial of exactly zero for the first item: k1 = -1, centre at origin, r2 = 1
        write_reg(CFG_CENTER_X, 0);
        write_reg(CFG_CENTER_Y, 0);
        write_reg(CFG_RADIAL_K1, -65536);
        write_reg(CFG_RADIAL_K2, 0);
        write_reg(CFG_RADIAL_K3, 0);
        write_reg(CFG_TANGENT_P1, 0);
        write_reg(CFG_TANGENT_P2, 0);
        write_reg(CFG_ASPECT_RATIO, 65536);
        send_coord(17'd65536 - 17'd3277, 17'd32768, 1'b0, 1'b0);
        send_coord(17'd32768, 17'd65536, 1'b0, 1'b0);
        drain_pipeline();
    endtask

    task automatic test_random_phase(int count, bit wild);
        int i;
        if (wild) begin
            for (i = 0; i < 8; i++) write_reg(3'(i), longint'($urandom_range(0, 24'hFFFFFF)));
        end else begin
            write_reg(CFG_CENTER_X, $urandom_range(0, 26000) - 13000);
            write_reg(CFG_CENTER_Y, $urandom_range(0, 26000) - 13000);
            write_reg(CFG_RADIAL_K1, $urandom_range(0, 80000) - 20000);
            write_reg(CFG_RADIAL_K2, $urandom_range(0, 20000) - 10000);
            write_reg(CFG_RADIAL_K3, $urandom_range(0, 20000) - 10000);
            write_reg(CFG_TANGENT_P1, $urandom_range(0, 8000) - 4000);
            write_reg(CFG_TANGENT_P2, $urandom_range(0, 8000) - 4000);
            write_reg(CFG_ASPECT_RATIO, $urandom_range(32768, 200000));
        end
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_coord(17'($urandom), 17'($urandom), 1'($urandom), 1'b1);
            else
                send_coord(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                           1'($urandom), (i % 60) >= 20);
        end
        drain_pipeline();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!sink_stall_on) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_coords.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = expected_coords.pop_front();
                if (o_out_data.mapped_u !== want.mapped_u)
                    report_mismatch("mapped_u", o_out_data.mapped_u, want.mapped_u);
                if (o_out_data.mapped_v !== want.mapped_v)
                    report_mismatch("mapped_v", o_out_data.mapped_v, want.mapped_v);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int phase;
        load_reset_values();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_config_extremes();
        for (phase = 0; phase < 5; phase++) begin
            sink_stall_on = (phase != 2);
            test_random_phase(87, phase == 4);
        end
        if (mismatch_count == 0 && expected_coords.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ldm_pkg.sv
rtl/ldm_div.sv
rtl/lens_distortion_uv_mapper.sv
bench/lens_distortion_uv_mapper_tb.sv
